// ===== src/efst_pkg.sv =====
// Package for the event-flag scheduler with timers.
// Field widths, operation and status codes, masks and the timer slot entry type.
// No dependencies.
package efst_pkg;

  localparam int OpW     = 3;
  localparam int TaskW   = 2;
  localparam int EventW  = 32;
  localparam int TmoW    = 16;
  localparam int StatusW = 3;
  localparam int CountW  = 5;
  localparam int TimeW   = 32;

  localparam int TimerSlotsDef = 16;
  localparam int TaskCountDef  = 3;

  localparam logic [OpW-1:0] OpTick     = 3'd0;
  localparam logic [OpW-1:0] OpStart    = 3'd1;
  localparam logic [OpW-1:0] OpClear    = 3'd2;
  localparam logic [OpW-1:0] OpPost     = 3'd3;
  localparam logic [OpW-1:0] OpDispatch = 3'd4;

  localparam logic [StatusW-1:0] StOk          = 3'd0;
  localparam logic [StatusW-1:0] StNoFreeSlot  = 3'd1;
  localparam logic [StatusW-1:0] StBadTask     = 3'd2;
  localparam logic [StatusW-1:0] StNoMatch     = 3'd3;
  localparam logic [StatusW-1:0] StNothingPend = 3'd4;

  localparam logic [EventW-1:0] DispatchMask = 32'h0000_FFFF;
  localparam logic [EventW-1:0] MatchMask    = 32'h0000_00FF;
  localparam logic [CountW-1:0] CountMax     = 5'd31;

  typedef struct packed {
    logic [TaskW-1:0]  slot_task;
    logic [EventW-1:0] slot_events;
    logic [TimeW-1:0]  slot_deadline;
  } slot_entry_t;

endpackage

// ===== src/efst_in_if.sv =====
// Input channel of the event-flag scheduler: valid/ready plus the request word.
// Depends on efst_pkg for field widths.
interface efst_in_if;
  logic                         valid;
  logic                         ready;
  logic [efst_pkg::OpW-1:0]     operation;
  logic [efst_pkg::TaskW-1:0]   task_req;
  logic [efst_pkg::EventW-1:0]  events;
  logic [efst_pkg::TmoW-1:0]    timeout_ms;

  modport source (output valid, operation, task_req, events, timeout_ms, input ready);
  modport sink   (input valid, operation, task_req, events, timeout_ms, output ready);
endinterface

// ===== src/efst_out_if.sv =====
// Output channel of the event-flag scheduler: valid/ready plus the result word.
// Depends on efst_pkg for field widths.
interface efst_out_if;
  logic                          valid;
  logic                          ready;
  logic [efst_pkg::StatusW-1:0]  status;
  logic [efst_pkg::TaskW-1:0]    served_task;
  logic [efst_pkg::EventW-1:0]   served_events;
  logic [efst_pkg::CountW-1:0]   expired_count;

  modport source (output valid, status, served_task, served_events, expired_count,
                  input ready);
  modport sink   (input valid, status, served_task, served_events, expired_count,
                  output ready);
endinterface

// ===== src/efst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/event_flag_scheduler_with_timers_top.sv =====
// Event-flag scheduler with a table of delayed-event timer slots.
// Depends on efst_pkg, efst_in_if, efst_out_if and efst_ram.
//
//   channel  dir  modport  word
//   in_i     in   sink     operation, task_req, events, timeout_ms
//   out_o    out  source   status, served_task, served_events, expired_count
//
// Tick, start and clear walk the slot RAM one slot a cycle; tick and start share
// one 32-bit adder. Start and clear end the walk early when they hit a slot.
// Post, dispatch and rejected requests skip the walk and go straight to the result.
// Reset clears the enable bits, task words and millisecond counter at once;
// slot RAM contents need no clearing. in_i.ready is low while an item is in
// work; a finished word waits in the output register while out_o.ready is low.
module event_flag_scheduler_with_timers_top #(
  parameter int TIMER_SLOTS = efst_pkg::TimerSlotsDef,
  parameter int TASK_COUNT  = efst_pkg::TaskCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  efst_in_if.sink    in_i,
  efst_out_if.source out_o
);

  localparam int SlotIdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SlotCntW = $clog2(TIMER_SLOTS + 1);
  localparam int EntryW   = $bits(efst_pkg::slot_entry_t);

  localparam logic [1:0] StateIdle = 2'd0;
  localparam logic [1:0] StateScan = 2'd1;
  localparam logic [1:0] StateDone = 2'd2;

  logic [1:0] state_q, state_d;

  logic [efst_pkg::OpW-1:0]    op_q;
  logic [efst_pkg::TaskW-1:0]  task_q;
  logic [efst_pkg::EventW-1:0] events_q;
  logic [efst_pkg::TmoW-1:0]   tmo_q;

  logic [efst_pkg::TimeW-1:0]  time_now_q, time_now_d;
  logic [TIMER_SLOTS-1:0]      en_q, en_d;
  logic [efst_pkg::EventW-1:0] flags_q [TASK_COUNT];
  logic [efst_pkg::EventW-1:0] flags_d [TASK_COUNT];

  logic [SlotCntW-1:0] idx_q, idx_d;
  logic                eval_vld_q, eval_vld_d;
  logic [SlotIdxW-1:0] eval_idx_q, eval_idx_d;

  logic [efst_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [efst_pkg::TaskW-1:0]   res_task_q, res_task_d;
  logic [efst_pkg::EventW-1:0]  res_events_q, res_events_d;
  logic [efst_pkg::CountW-1:0]  fired_q, fired_d;

  logic out_valid_q, out_valid_d;
  logic out_load;

  // slot RAM
  logic                  ram_we;
  efst_pkg::slot_entry_t ram_wdata, ram_rdata;
  logic [EntryW-1:0]     ram_rdata_raw;

  efst_ram #(
    .Width (EntryW),
    .Depth (TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (eval_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[SlotIdxW-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = efst_pkg::slot_entry_t'(ram_rdata_raw);

  // shared adder: now + timeout for start, now - deadline for tick
  logic [efst_pkg::TimeW-1:0] add_b;
  logic                       add_cin;
  logic [efst_pkg::TimeW-1:0] add_sum;
  logic                       deadline_passed;

  always_comb begin
    if (op_q == efst_pkg::OpStart) begin
      add_b   = efst_pkg::TimeW'(tmo_q);
      add_cin = 1'b0;
    end else begin
      add_b   = ~ram_rdata.slot_deadline;
      add_cin = 1'b1;
    end
  end

  assign add_sum         = time_now_q + add_b + efst_pkg::TimeW'(add_cin);
  assign deadline_passed = (add_sum != '0) && !add_sum[efst_pkg::TimeW-1];

  assign ram_wdata.slot_task     = task_q;
  assign ram_wdata.slot_events   = events_q;
  assign ram_wdata.slot_deadline = add_sum;

  logic task_bad;
  assign task_bad = {1'b0, in_i.task_req} >= (efst_pkg::TaskW + 1)'(TASK_COUNT);

  logic scan_end;
  assign scan_end = !eval_vld_q && (idx_q == SlotCntW'(TIMER_SLOTS));

  assign in_i.ready = (state_q == StateIdle);
  assign out_load   = (state_q == StateDone) && (!out_valid_q || out_o.ready);

  always_comb begin
    logic found;
    state_d      = state_q;
    time_now_d   = time_now_q;
    en_d         = en_q;
    flags_d      = flags_q;
    idx_d        = idx_q;
    eval_vld_d   = 1'b0;
    eval_idx_d   = eval_idx_q;
    res_status_d = res_status_q;
    res_task_d   = res_task_q;
    res_events_d = res_events_q;
    fired_d      = fired_q;
    ram_we       = 1'b0;
    found        = 1'b0;

    case (state_q)
      StateIdle: begin
        if (in_i.valid) begin
          res_status_d = efst_pkg::StOk;
          res_task_d   = '0;
          res_events_d = '0;
          fired_d      = '0;
          idx_d        = '0;
          state_d      = StateDone;
          case (in_i.operation)
            efst_pkg::OpTick: begin
              time_now_d = time_now_q + 1'b1;
              state_d    = StateScan;
            end
            efst_pkg::OpStart, efst_pkg::OpClear: begin
              if (task_bad) begin
                res_status_d = efst_pkg::StBadTask;
              end else begin
                state_d = StateScan;
              end
            end
            efst_pkg::OpPost: begin
              if (task_bad) begin
                res_status_d = efst_pkg::StBadTask;
              end else begin
                for (int t = 0; t < TASK_COUNT; t++) begin
                  if (in_i.task_req == efst_pkg::TaskW'(t)) begin
                    flags_d[t] = flags_q[t] | in_i.events;
                  end
                end
              end
            end
            efst_pkg::OpDispatch: begin
              res_status_d = efst_pkg::StNothingPend;
              for (int t = 0; t < TASK_COUNT; t++) begin
                if (!found && ((flags_q[t] & efst_pkg::DispatchMask) != '0)) begin
                  found        = 1'b1;
                  res_status_d = efst_pkg::StOk;
                  res_task_d   = efst_pkg::TaskW'(t);
                  res_events_d = flags_q[t];
                  flags_d[t]   = '0;
                end
              end
            end
            default: begin
              // unused codes answer ok and change nothing
            end
          endcase
        end
      end

      StateScan: begin
        // issue the next read while the previous slot is evaluated
        if (idx_q != SlotCntW'(TIMER_SLOTS)) begin
          eval_vld_d = 1'b1;
          eval_idx_d = idx_q[SlotIdxW-1:0];
          idx_d      = idx_q + 1'b1;
        end
        if (eval_vld_q) begin
          case (op_q)
            efst_pkg::OpTick: begin
              if (en_q[eval_idx_q] && deadline_passed) begin
                en_d[eval_idx_q] = 1'b0;
                for (int t = 0; t < TASK_COUNT; t++) begin
                  if (ram_rdata.slot_task == efst_pkg::TaskW'(t)) begin
                    flags_d[t] = flags_q[t] | ram_rdata.slot_events;
                  end
                end
                if (fired_q != efst_pkg::CountMax) begin
                  fired_d = fired_q + 1'b1;
                end
              end
            end
            efst_pkg::OpStart: begin
              if (!en_q[eval_idx_q]) begin
                en_d[eval_idx_q] = 1'b1;
                ram_we           = 1'b1;
                res_status_d     = efst_pkg::StOk;
                state_d          = StateDone;
              end
            end
            efst_pkg::OpClear: begin
              if (en_q[eval_idx_q] && (ram_rdata.slot_task == task_q) &&
                  ((ram_rdata.slot_events & efst_pkg::MatchMask) ==
                   (events_q & efst_pkg::MatchMask))) begin
                en_d[eval_idx_q] = 1'b0;
                res_status_d     = efst_pkg::StOk;
                state_d          = StateDone;
              end
            end
            default: begin
              state_d = StateDone;
            end
          endcase
        end else if (scan_end) begin
          state_d = StateDone;
          case (op_q)
            efst_pkg::OpStart: res_status_d = efst_pkg::StNoFreeSlot;
            efst_pkg::OpClear: res_status_d = efst_pkg::StNoMatch;
            default:           res_status_d = efst_pkg::StOk;
          endcase
        end
      end

      StateDone: begin
        if (out_load) begin
          state_d = StateIdle;
        end
      end

      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      time_now_q  <= '0;
      en_q        <= '0;
      idx_q       <= '0;
      eval_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int t = 0; t < TASK_COUNT; t++) begin
        flags_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      time_now_q  <= time_now_d;
      en_q        <= en_d;
      idx_q       <= idx_d;
      eval_vld_q  <= eval_vld_d;
      out_valid_q <= out_valid_d;
      flags_q     <= flags_d;
    end
  end

  // request and result words
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q     <= in_i.operation;
      task_q   <= in_i.task_req;
      events_q <= in_i.events;
      tmo_q    <= in_i.timeout_ms;
    end
    eval_idx_q   <= eval_idx_d;
    res_status_q <= res_status_d;
    res_task_q   <= res_task_d;
    res_events_q <= res_events_d;
    fired_q      <= fired_d;
    if (out_load) begin
      out_o.status        <= res_status_q;
      out_o.served_task   <= res_task_q;
      out_o.served_events <= res_events_q;
      out_o.expired_count <= fired_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== tb/sv/event_flag_scheduler_with_timers_top_tb.sv =====
// Testbench for event_flag_scheduler_with_timers_top: a directed table, then random
// bursts checked against an in-bench scheduler predictor, with random stalls on both sides.
// Depends on efst_pkg, efst_in_if, efst_out_if and the top level under test.
module event_flag_scheduler_with_timers_top_tb;
  import efst_pkg::*;

  localparam int          Slots      = TimerSlotsDef;
  localparam int          Tasks      = TaskCountDef;
  localparam int          NumRows    = 27;
  localparam int          RandItems  = 710;
  localparam int          DrainEvery = 300;
  localparam int          LongHold   = 400;
  localparam logic [OpW-1:0]   OpUnused5 = 3'd5;
  localparam logic [OpW-1:0]   OpUnused7 = 3'd7;
  localparam logic [TaskW-1:0] TaskTop   = '1;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [TaskW-1:0]  task_id;
    logic [EventW-1:0] events;
    logic [TmoW-1:0]   timeout;
  } sched_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TaskW-1:0]   served_task;
    logic [EventW-1:0]  served_events;
    logic [CountW-1:0]  expired;
  } sched_rsp_t;

  typedef struct {
    sched_req_t  rq;
    int unsigned reps;
    bit          pinned;
    sched_rsp_t  rsp;
  } sched_row_t;

  logic clk_i;
  logic rst_ni;

  efst_in_if  in_ch ();
  efst_out_if out_ch ();

  event_flag_scheduler_with_timers_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predictor state
  logic              slot_on       [Slots];
  logic [TaskW-1:0]  slot_owner    [Slots];
  logic [EventW-1:0] slot_events   [Slots];
  logic [TimeW-1:0]  slot_deadline [Slots];
  logic [EventW-1:0] flag_word     [Tasks];
  logic [TimeW-1:0]  now_ms;

  sched_rsp_t  expected_q [$];
  int unsigned mismatch_count;
  int unsigned words_out;

  sched_row_t directed_rows [NumRows] = '{
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StNothingPend, 2'd0, 32'h0, 5'd0}},
    '{'{OpTick, TaskTop, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpPost, TaskTop, 32'hFFFF_FFFF, 16'h0}, 1, 1'b1, '{StBadTask, 2'd0, 32'h0, 5'd0}},
    '{'{OpStart, TaskTop, 32'h1, 16'hFFFF}, 1, 1'b1, '{StBadTask, 2'd0, 32'h0, 5'd0}},
    '{'{OpClear, TaskTop, 32'hFF, 16'h0}, 1, 1'b1, '{StBadTask, 2'd0, 32'h0, 5'd0}},
    '{'{OpUnused5, TaskTop, 32'hFFFF_FFFF, 16'hFFFF}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpUnused7, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpPost, 2'd0, 32'hFFFF_0000, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StNothingPend, 2'd0, 32'h0, 5'd0}},
    '{'{OpPost, 2'd2, 32'h0000_0001, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd2, 32'h0000_0001, 5'd0}},
    '{'{OpStart, 2'd0, 32'hFFFF_FFFF, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpStart, 2'd1, 32'h0000_00AA, 16'hFFFF}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpClear, 2'd1, 32'h0000_0055, 16'h0}, 1, 1'b1, '{StNoMatch, 2'd0, 32'h0, 5'd0}},
    '{'{OpClear, 2'd0, 32'h1234_56AA, 16'h0}, 1, 1'b1, '{StNoMatch, 2'd0, 32'h0, 5'd0}},
    '{'{OpClear, 2'd1, 32'hFFFF_FFAA, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpTick, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd1}},
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'hFFFF_FFFF, 5'd0}},
    '{'{OpStart, 2'd2, 32'h8000_0001, 16'h0}, Slots, 1'b1, '{StOk, 2'd0, 32'h0, 5'd0}},
    '{'{OpStart, 2'd1, 32'h0, 16'h0}, 1, 1'b1, '{StNoFreeSlot, 2'd0, 32'h0, 5'd0}},
    '{'{OpTick, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd0, 32'h0, 5'd16}},
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b1, '{StOk, 2'd2, 32'h8000_0001, 5'd0}},
    '{'{OpStart, 2'd1, 32'h0000_0100, 16'h1}, 1, 1'b0, '0},
    '{'{OpTick, 2'd0, 32'h0, 16'h0}, 1, 1'b0, '0},
    '{'{OpTick, 2'd0, 32'h0, 16'h0}, 1, 1'b0, '0},
    '{'{OpPost, 2'd1, 32'h0000_8000, 16'h0}, 1, 1'b0, '0},
    '{'{OpDispatch, 2'd0, 32'h0, 16'h0}, 1, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Advance the scheduler state by one request and return its result word.
  function automatic sched_rsp_t scheduler_step(input sched_req_t rq);
    sched_rsp_t       rs;
    logic [TimeW-1:0] diff;
    bit               hit;
    rs  = '0;
    hit = 1'b0;
    case (rq.op)
      OpTick: begin
        now_ms = now_ms + 1'b1;
        for (int i = 0; i < Slots; i++) begin
          diff = now_ms - slot_deadline[i];
          // wrap-safe: deadline passed when the difference is positive as signed
          if (slot_on[i] && diff != '0 && !diff[TimeW-1]) begin
            flag_word[slot_owner[i]] |= slot_events[i];
            slot_on[i] = 1'b0;
            if (rs.expired != CountMax) rs.expired = rs.expired + 1'b1;
          end
        end
      end
      OpStart: begin
        if (rq.task_id >= Tasks) begin
          rs.status = StBadTask;
        end else begin
          rs.status = StNoFreeSlot;
          for (int i = 0; i < Slots; i++) begin
            if (!hit && !slot_on[i]) begin
              hit              = 1'b1;
              slot_on[i]       = 1'b1;
              slot_owner[i]    = rq.task_id;
              slot_events[i]   = rq.events;
              slot_deadline[i] = now_ms + TimeW'(rq.timeout);
              rs.status        = StOk;
            end
          end
        end
      end
      OpClear: begin
        if (rq.task_id >= Tasks) begin
          rs.status = StBadTask;
        end else begin
          rs.status = StNoMatch;
          for (int i = 0; i < Slots; i++) begin
            if (!hit && slot_on[i] && slot_owner[i] == rq.task_id &&
                (slot_events[i] & MatchMask) == (rq.events & MatchMask)) begin
              hit        = 1'b1;
              slot_on[i] = 1'b0;
              rs.status  = StOk;
            end
          end
        end
      end
      OpPost: begin
        if (rq.task_id >= Tasks) rs.status = StBadTask;
        else flag_word[rq.task_id] |= rq.events;
      end
      OpDispatch: begin
        rs.status = StNothingPend;
        for (int i = 0; i < Tasks; i++) begin
          if (!hit && (flag_word[i] & DispatchMask) != '0) begin
            hit              = 1'b1;
            rs.status        = StOk;
            rs.served_task   = TaskW'(i);
            rs.served_events = flag_word[i];
            flag_word[i]     = '0;
          end
        end
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic sched_req_t make_random_req();
    sched_req_t  rq;
    int unsigned pick;
    int unsigned armed;
    int unsigned which;
    rq.events  = $urandom();
    rq.task_id = ($urandom_range(0, 9) == 0) ? TaskTop : TaskW'($urandom_range(0, Tasks - 1));
    pick = $urandom_range(0, 99);
    if (pick < 20)      rq.timeout = TmoW'($urandom());
    else if (pick < 35) rq.timeout = TmoW'($urandom_range(13, 300));
    else                rq.timeout = TmoW'($urandom_range(0, 12));
    pick = $urandom_range(0, 99);
    if (pick < 30)      rq.op = OpTick;
    else if (pick < 52) rq.op = OpStart;
    else if (pick < 67) rq.op = OpClear;
    else if (pick < 82) rq.op = OpPost;
    else if (pick < 96) rq.op = OpDispatch;
    else                rq.op = OpW'($urandom_range(OpUnused5, OpUnused7));
    // keep long timeouts rare so slots keep turning over
    if (rq.op == OpStart && rq.timeout > 300 && $urandom_range(0, 3) != 0)
      rq.timeout = TmoW'($urandom_range(0, 12));
    // few distinct low bytes so clears find duplicates
    if (rq.op == OpStart && $urandom_range(0, 1) == 0)
      rq.events[7:0] = 8'($urandom_range(0, 7));
    if (rq.op == OpPost && $urandom_range(0, 3) == 0)
      rq.events = rq.events & ~DispatchMask;
    if (rq.op == OpClear && $urandom_range(0, 9) < 7) begin
      armed = 0;
      for (int i = 0; i < Slots; i++) if (slot_on[i]) armed++;
      if (armed != 0) begin
        which = $urandom_range(0, armed - 1);
        for (int i = 0; i < Slots; i++) begin
          if (slot_on[i]) begin
            if (which == 0) begin
              rq.task_id     = slot_owner[i];
              rq.events[7:0] = slot_events[i][7:0];
            end
            which--;
          end
        end
      end
    end
    return rq;
  endfunction

  // Offer one word and hold it until taken; predict at the accepting edge.
  task automatic offer_word(input sched_req_t rq, input bit pinned, input sched_rsp_t pin_rsp);
    sched_rsp_t predicted;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= rq.op;
    in_ch.task_req   <= rq.task_id;
    in_ch.events     <= rq.events;
    in_ch.timeout_ms <= rq.timeout;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = scheduler_step(rq);
    expected_q.push_back(pinned ? pin_rsp : predicted);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned next_drain;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = '0;
    in_ch.task_req   = '0;
    in_ch.events     = '0;
    in_ch.timeout_ms = '0;
    mismatch_count   = 0;
    for (int i = 0; i < Slots; i++) begin
      slot_on[i]       = 1'b0;
      slot_owner[i]    = '0;
      slot_events[i]   = '0;
      slot_deadline[i] = '0;
    end
    for (int i = 0; i < Tasks; i++) flag_word[i] = '0;
    now_ms = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      for (int n = 0; n < directed_rows[r].reps; n++)
        offer_word(directed_rows[r].rq, directed_rows[r].pinned, directed_rows[r].rsp);

    sent       = 0;
    next_drain = DrainEvery;
    while (sent < RandItems) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RandItems; k++) begin
        offer_word(make_random_req(), 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (sent >= next_drain) begin
        // pause until every outstanding word is back
        next_drain += DrainEvery;
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end else if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: random stall segments, plus one long hold-off once traffic is flowing.
  initial begin : receiver
    int unsigned seg;
    int unsigned mode;
    bit          held;
    out_ch.ready = 1'b0;
    held         = 1'b0;
    forever begin
      if (!held && words_out >= 150) begin
        held = 1'b1;
        for (int n = 0; n < LongHold; n++) begin
          @(posedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end
      seg  = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      for (int n = 0; n < seg; n++) begin
        @(posedge clk_i);
        case (mode)
          0, 1:    out_ch.ready <= 1'b1;
          2:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sched_rsp_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected, status %0d",
                                  out_ch.status));
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_ch.status, want.status));
        if (out_ch.served_task !== want.served_task)
          report_mismatch($sformatf("served_task got %0d expected %0d",
                                    out_ch.served_task, want.served_task));
        if (out_ch.served_events !== want.served_events)
          report_mismatch($sformatf("served_events got %h expected %h",
                                    out_ch.served_events, want.served_events));
        if (out_ch.expired_count !== want.expired)
          report_mismatch($sformatf("expired_count got %0d expected %0d",
                                    out_ch.expired_count, want.expired));
      end
    end
  end

  initial words_out = 0;

endmodule
